// ----- sv/asrt_pkg.sv -----
`default_nettype none

package asrt_pkg;

    localparam int ASRT_CAPACITY  = 8;
    localparam int ASRT_VALUE_W   = 32;

    typedef logic signed [ASRT_VALUE_W-1:0] sample_t;

    // what one cell shows its neighbours
    typedef struct packed {
        logic    valid;
        logic    gt;      // held word is greater than the word on the insert bus
        sample_t value;
    } cell_tap_t;

    typedef struct packed {
        logic ins;        // insert the broadcast word
        logic shl;        // shift towards cell 0 (emit)
    } cell_ctrl_t;

    typedef enum logic {
        ST_COLLECT,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

// ----- sv/asrt_cell.sv -----
`default_nettype none

module asrt_cell
    import asrt_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire cell_ctrl_t ctrl,
    input  wire sample_t   in_value,
    input  wire cell_tap_t left_tap,
    input  wire cell_tap_t right_tap,
    output cell_tap_t      tap
);

    sample_t value_reg;
    sample_t value_next;
    logic    valid_reg;
    logic    valid_next;
    logic    gt;
    logic    take;

    // strict compare: an equal newcomer lands behind, so arrival order holds
    assign gt   = valid_reg && (value_reg > in_value);
    assign take = gt || (!valid_reg && left_tap.valid);

    always_comb begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.shl) begin
            value_next = right_tap.value;
            valid_next = right_tap.valid;
        end else if (ctrl.ins && take) begin
            // either the left neighbour moves up, or the new word goes here
            value_next = left_tap.gt ? left_tap.value : in_value;
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign tap.valid = valid_reg;
    assign tap.gt    = gt;
    assign tap.value = value_reg;

endmodule

`default_nettype wire

// ----- sv/ascending_integer_sorter.sv -----
`default_nettype none

// Channel  Dir  Fields (tdata from bit 0 up)      Marker
// s_       in   tdata[31:0] sample_value (signed)  tlast = set_end
// m_       out  tdata[31:0] sorted_value (signed)  tlast = final_flag
//
// Each accepted word is inserted into a sorted row of CAPACITY cells.
// After the word marked last, one result per cycle leaves cell 0 while m_tready
// is high. No words are taken while a set is emitted. Reset empties the row.
// Stalls on m_tready simply hold the row; words beyond CAPACITY are dropped.

module ascending_integer_sorter
    import asrt_pkg::*;
#(
    parameter int CAPACITY = ASRT_CAPACITY
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] sample_value
    input  wire logic        s_tlast,   // set_end
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // [31:0] sorted_value
    output logic             m_tlast    // final_flag
);

    state_t     state_reg;
    state_t     state_next;
    cell_ctrl_t ctrl;
    cell_tap_t  taps [CAPACITY];
    sample_t    in_value;

    localparam cell_tap_t HEAD_TAP = '{valid: 1'b1, gt: 1'b0, value: '0};
    localparam cell_tap_t TAIL_TAP = '{valid: 1'b0, gt: 1'b0, value: '0};

    assign in_value = sample_t'(s_tdata);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_COLLECT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        ctrl       = '0;
        unique case (state_reg)
            ST_COLLECT: begin
                s_tready = 1'b1;
                // full row: the word is dropped but a closing mark still counts
                ctrl.ins = s_tvalid && !taps[CAPACITY-1].valid;
                if (s_tvalid && s_tlast) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                m_tvalid = taps[0].valid;
                ctrl.shl = m_tready && taps[0].valid;
                if (ctrl.shl && !taps[1].valid) begin
                    state_next = ST_COLLECT;
                end
            end
            default: begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        cell_tap_t left_tap;
        cell_tap_t right_tap;

        if (i == 0) begin : g_head
            assign left_tap = HEAD_TAP;
        end else begin : g_left
            assign left_tap = taps[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign right_tap = TAIL_TAP;
        end else begin : g_right
            assign right_tap = taps[i+1];
        end

        asrt_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .in_value  (in_value),
            .left_tap  (left_tap),
            .right_tap (right_tap),
            .tap       (taps[i])
        );
    end

    assign m_tdata = 32'(taps[0].value);
    assign m_tlast = !taps[1].valid;

endmodule

`default_nettype wire
